[rtl/assert_macros.svh]
// assertion macros used by rssi_noise_floor_tracker_core
// no dependencies; defining SYNTH leaves every macro empty
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/rnft_pkg.sv]
// constants and types of the rssi noise floor tracker
// no dependencies; used by rssi_noise_floor_tracker_core
`default_nettype none

package rnft_pkg;

   localparam int RSSI_W           = 9;
   localparam int FLOOR_W          = 8;
   localparam int THRESH_W         = 7;
   localparam int NUM_SAMPLES_DEF  = 64;
   localparam int ACCEPT_MARGIN    = 14;
   localparam int FLOOR_MIN        = -120;
   localparam int FLOOR_MAX        = 127;
   // width for floor/rssi compares: floor plus threshold or margin
   localparam int CMP_W            = 10;

   typedef struct packed {
      logic signed [RSSI_W-1:0] rssi;
      logic                     listening;
      logic                     packet_in_progress;
      logic                     restart_calibration;
      logic                     clear_floor;
   } req_item_type;

   typedef struct packed {
      logic signed [FLOOR_W-1:0] floor_level;
      logic                      calibrating;
      logic                      channel_busy;
      logic                      floor_updated;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/rssi_noise_floor_tracker_core.sv]
// rssi noise floor tracker, top level
// depends on rnft_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// usage
//  - request channel: req_valid/req_stall carry one rssi sample plus the
//    listening, packet_in_progress, restart_calibration and clear_floor flags
//  - response channel: rsp_valid/rsp_stall carry one response per request:
//    noise floor after the request, calibrating, channel busy, floor updated
//  - csr_wr_en/csr_wr_data write the busy threshold (0 turns the busy check
//    off); write it only while no request is in flight
//  - a request taken into the request register passes to the response
//    register, which drives rsp_*; one request per cycle unless stalled
//  - the state update is one pass of logic between the two registers, with
//    a single constant-reciprocal multiply for the average of the run
//  - reset (synchronous, active high) zeroes floor, count, sum, threshold
//    and empties both registers
//  - while rsp_stall is high the response holds; a new request is still
//    taken into the request register, and req_stall rises only when that
//    register is full and the response cannot move
module rssi_noise_floor_tracker_core #(
   parameter int NUM_SAMPLES = rnft_pkg::NUM_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rnft_pkg::RSSI_W-1:0]  req_rssi,
   input  logic                                req_listening,
   input  logic                                req_packet_in_progress,
   input  logic                                req_restart_calibration,
   input  logic                                req_clear_floor,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rnft_pkg::FLOOR_W-1:0] rsp_floor_level,
   output logic                                rsp_calibrating,
   output logic                                rsp_channel_busy,
   output logic                                rsp_floor_updated,
   // threshold register
   input  logic                                csr_wr_en,
   input  logic [rnft_pkg::THRESH_W-1:0]       csr_wr_data
);

   import rnft_pkg::*;

   // sample counter holds 0..NUM_SAMPLES, sum holds NUM_SAMPLES full-range samples
   localparam int CNT_W   = $clog2(NUM_SAMPLES + 1);
   localparam int LOG_N   = $clog2(NUM_SAMPLES);
   localparam int SUM_W   = RSSI_W + LOG_N;
   // truncating divide by NUM_SAMPLES: q = (|sum| * MULT) >> SHIFT, exact for |sum| < 2^SUM_W
   localparam int SHIFT   = SUM_W + LOG_N;
   localparam int MULT_W  = SUM_W + 1;
   localparam int PROD_W  = SUM_W + MULT_W;
   localparam int AVG_W   = RSSI_W + 1;

   localparam logic [MULT_W-1:0]       DIV_MULT =
      MULT_W'(((64'd1 << SHIFT) + 64'(NUM_SAMPLES) - 64'd1) / 64'(NUM_SAMPLES));
   localparam logic [CNT_W-1:0]        CNT_FULL = CNT_W'(NUM_SAMPLES);
   localparam logic signed [CMP_W-1:0] MARGIN_V = CMP_W'(ACCEPT_MARGIN);
   localparam logic signed [AVG_W-1:0] AVG_MIN  = AVG_W'(FLOOR_MIN);
   localparam logic signed [AVG_W-1:0] AVG_MAX  = AVG_W'(FLOOR_MAX);

   // handshake and pipeline registers
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         advance;

   // tracker state
   logic signed [FLOOR_W-1:0] floor_ff, floor_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [THRESH_W-1:0]       thresh_ff;

   // datapath
   logic signed [FLOOR_W-1:0] floor_clr;
   logic [CNT_W-1:0]          cnt_clr, cnt_rst;
   logic signed [SUM_W-1:0]   sum_clr, sum_rst;
   logic                      collect_open, take_sample, avg_due, upd_in;
   logic                      sum_neg;
   logic [SUM_W-1:0]          sum_mag;
   logic [PROD_W-1:0]         prod;
   logic [RSSI_W-1:0]         quo;
   logic signed [AVG_W-1:0]   avg;
   logic signed [FLOOR_W-1:0] avg_clamped;
   logic signed [CMP_W-1:0]   rssi_ext, accept_lim, busy_lim;
   logic                      busy_in;
   rsp_item_type              rsp_in;

   // a request moves from the request register to the response register
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff.rssi                <= req_rssi;
         in_item_ff.listening           <= req_listening;
         in_item_ff.packet_in_progress  <= req_packet_in_progress;
         in_item_ff.restart_calibration <= req_restart_calibration;
         in_item_ff.clear_floor         <= req_clear_floor;
      end
   end

   // magnitude of the stored sum times the reciprocal; only read when the
   // sum is untouched by clear or restart in this request
   assign sum_neg = sum_ff[SUM_W-1];
   assign sum_mag = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign prod    = {{MULT_W{1'b0}}, sum_mag} * {{SUM_W{1'b0}}, DIV_MULT};
   assign quo     = prod[SHIFT +: RSSI_W];
   assign avg     = sum_neg ? -AVG_W'(quo) : AVG_W'(quo);

   always_comb begin
      priority if (avg < AVG_MIN) begin
         avg_clamped = FLOOR_W'(AVG_MIN);
      end else if (avg > AVG_MAX) begin
         avg_clamped = FLOOR_W'(AVG_MAX);
      end else begin
         avg_clamped = FLOOR_W'(avg);
      end
   end

   always_comb begin
      // front-end reset clears floor, count and sum first
      floor_clr = in_item_ff.clear_floor ? '0 : floor_ff;
      cnt_clr   = in_item_ff.clear_floor ? '0 : cnt_ff;
      sum_clr   = in_item_ff.clear_floor ? '0 : sum_ff;

      // restart only after a finished run
      if (in_item_ff.restart_calibration && (cnt_clr >= CNT_FULL)) begin
         cnt_rst = '0;
         sum_rst = '0;
      end else begin
         cnt_rst = cnt_clr;
         sum_rst = sum_clr;
      end

      rssi_ext     = CMP_W'(in_item_ff.rssi);
      accept_lim   = CMP_W'(floor_clr) + MARGIN_V;
      collect_open = in_item_ff.listening && (cnt_rst < CNT_FULL);
      take_sample  = collect_open && !in_item_ff.packet_in_progress
                     && (rssi_ext < accept_lim);
      avg_due      = !collect_open && (cnt_rst >= CNT_FULL) && (sum_rst != '0);

      floor_in = floor_clr;
      cnt_in   = cnt_rst;
      sum_in   = sum_rst;
      upd_in   = 1'b0;
      if (take_sample) begin
         cnt_in = cnt_rst + CNT_W'(1);
         sum_in = sum_rst + SUM_W'(in_item_ff.rssi);
      end else if (avg_due) begin
         floor_in = avg_clamped;
         sum_in   = '0;
         upd_in   = 1'b1;
      end

      busy_lim = CMP_W'(floor_in) + CMP_W'(thresh_ff);
      busy_in  = (thresh_ff != '0) && (rssi_ext > busy_lim);

      rsp_in.floor_level   = floor_in;
      rsp_in.calibrating   = cnt_in < CNT_FULL;
      rsp_in.channel_busy  = busy_in;
      rsp_in.floor_updated = upd_in;
   end

   // tracker state advances once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
      end else if (advance) begin
         floor_ff <= floor_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_floor_level   = rsp_item_ff.floor_level;
   assign rsp_calibrating   = rsp_item_ff.calibrating;
   assign rsp_channel_busy  = rsp_item_ff.channel_busy;
   assign rsp_floor_updated = rsp_item_ff.floor_updated;

   // a new floor is only computed from a finished run
   `ASSERT_NEVER(a_upd_while_cal, clock, reset,
      rsp_valid_ff && rsp_item_ff.floor_updated && rsp_item_ff.calibrating)
   // the counter stops at the run length
   `ASSERT_CLK(a_cnt_bound, clock, reset, cnt_ff <= CNT_FULL)
   // the stored floor never drops below the clamp
   `ASSERT_CLK(a_floor_min, clock, reset, floor_ff >= FLOOR_W'(FLOOR_MIN))
   // computing the floor consumes the sum
   `ASSERT_CLK(a_sum_consumed, clock, reset, (advance && upd_in) |=> (sum_ff == '0))

endmodule

`default_nettype wire

[bench/floor_tracker_checker.sv]
`timescale 1ns / 100ps
// response checker for the rssi noise floor tracker: watches the request, response
// and threshold ports, keeps its own floor/count/sum and compares every response
// depends on rnft_pkg
module floor_tracker_checker #(
   parameter int NUM_SAMPLES = rnft_pkg::NUM_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [rnft_pkg::RSSI_W-1:0]  req_rssi,
   input  logic                                req_listening,
   input  logic                                req_packet_in_progress,
   input  logic                                req_restart_calibration,
   input  logic                                req_clear_floor,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [rnft_pkg::FLOOR_W-1:0] rsp_floor_level,
   input  logic                                rsp_calibrating,
   input  logic                                rsp_channel_busy,
   input  logic                                rsp_floor_updated,
   input  logic                                csr_wr_en,
   input  logic [rnft_pkg::THRESH_W-1:0]       csr_wr_data,
   output int                                  error_count,
   output int                                  outstanding,
   output int                                  run_floor,
   output int                                  run_count
);
   import rnft_pkg::*;

   int           floor_est;
   int           sample_count;
   int           sample_sum;
   int           busy_thresh;
   rsp_item_type pending_reports[$];

   // floor tracking for one request, in the order clear, restart, collect or average
   function automatic rsp_item_type next_floor_report(input req_item_type r);
      rsp_item_type res;
      int           level;
      int           avg;
      logic         updated;
      level   = $signed(r.rssi);
      updated = 1'b0;
      if (r.clear_floor) begin
         floor_est    = 0;
         sample_count = 0;
         sample_sum   = 0;
      end
      if (r.restart_calibration && sample_count >= NUM_SAMPLES) begin
         sample_count = 0;
         sample_sum   = 0;
      end
      if (r.listening && sample_count < NUM_SAMPLES) begin
         if (!r.packet_in_progress && level < floor_est + ACCEPT_MARGIN) begin
            sample_count++;
            sample_sum += level;
         end
      end else if (sample_count >= NUM_SAMPLES && sample_sum != 0) begin
         avg = sample_sum / NUM_SAMPLES;
         if (avg < FLOOR_MIN) avg = FLOOR_MIN;
         if (avg > FLOOR_MAX) avg = FLOOR_MAX;
         floor_est  = avg;
         sample_sum = 0;
         updated    = 1'b1;
      end
      res.floor_level   = floor_est[FLOOR_W-1:0];
      res.calibrating   = (sample_count < NUM_SAMPLES);
      res.channel_busy  = (busy_thresh != 0) && (level > floor_est + busy_thresh);
      res.floor_updated = updated;
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_response();
      rsp_item_type want;
      if (pending_reports.size() == 0) begin
         report_error($sformatf("response with no request pending, floor %0d",
                                rsp_floor_level));
         return;
      end
      want = pending_reports.pop_front();
      if (rsp_floor_level !== want.floor_level)
         report_error($sformatf("floor_level %0d, expected %0d",
                                rsp_floor_level, want.floor_level));
      if (rsp_calibrating !== want.calibrating)
         report_error($sformatf("calibrating %b, expected %b",
                                rsp_calibrating, want.calibrating));
      if (rsp_channel_busy !== want.channel_busy)
         report_error($sformatf("channel_busy %b, expected %b",
                                rsp_channel_busy, want.channel_busy));
      if (rsp_floor_updated !== want.floor_updated)
         report_error($sformatf("floor_updated %b, expected %b",
                                rsp_floor_updated, want.floor_updated));
   endtask

   always @(posedge clock) begin
      req_item_type r;
      if (reset) begin
         floor_est    = 0;
         sample_count = 0;
         sample_sum   = 0;
         busy_thresh  = 0;
         error_count  = 0;
         pending_reports.delete();
      end else begin
         // older responses first, a request taken now cannot answer at this edge
         if (rsp_valid && !rsp_stall) check_response();
         if (req_valid && !req_stall) begin
            r.rssi                = req_rssi;
            r.listening           = req_listening;
            r.packet_in_progress  = req_packet_in_progress;
            r.restart_calibration = req_restart_calibration;
            r.clear_floor         = req_clear_floor;
            pending_reports.push_back(next_floor_report(r));
         end
         if (csr_wr_en) busy_thresh = csr_wr_data;
      end
      outstanding = pending_reports.size();
      run_floor   = floor_est;
      run_count   = sample_count;
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// top of the rssi noise floor tracker bench: clock, reset, request stimulus,
// threshold writes and the verdict; depends on rnft_pkg,
// rssi_noise_floor_tracker_core and floor_tracker_checker
module tb;
   import rnft_pkg::*;

   // cycles with nothing accepted on either channel before giving up
   localparam int WATCHDOG_LIMIT = 3000;
   // request total at the end of the first phase, and added per later phase
   localparam int FIRST_PHASE_ITEMS = 700;
   localparam int PHASE_ITEMS       = 330;

   // shapes of one calibration run
   typedef enum int {RUN_NORMAL, RUN_CLIMB, RUN_PLUNGE, RUN_ZERO} run_kind_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [RSSI_W-1:0]    req_rssi = '0;
   logic                        req_listening = 1'b0;
   logic                        req_packet_in_progress = 1'b0;
   logic                        req_restart_calibration = 1'b0;
   logic                        req_clear_floor = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [FLOOR_W-1:0]   rsp_floor_level;
   logic                        rsp_calibrating;
   logic                        rsp_channel_busy;
   logic                        rsp_floor_updated;
   logic                        csr_wr_en = 1'b0;
   logic [THRESH_W-1:0]         csr_wr_data = '0;

   int error_count;
   int outstanding;
   int run_floor;
   int run_count;

   // idle and stall odds in percent, set per phase
   int send_idle_pct = 0;
   int stall_pct = 0;
   int sent = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   rssi_noise_floor_tracker_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_rssi                (req_rssi),
      .req_listening           (req_listening),
      .req_packet_in_progress  (req_packet_in_progress),
      .req_restart_calibration (req_restart_calibration),
      .req_clear_floor         (req_clear_floor),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_floor_level         (rsp_floor_level),
      .rsp_calibrating         (rsp_calibrating),
      .rsp_channel_busy        (rsp_channel_busy),
      .rsp_floor_updated       (rsp_floor_updated),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data)
   );

   // predicts and compares; its floor and count steer the run shapes below
   floor_tracker_checker floor_check (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_rssi                (req_rssi),
      .req_listening           (req_listening),
      .req_packet_in_progress  (req_packet_in_progress),
      .req_restart_calibration (req_restart_calibration),
      .req_clear_floor         (req_clear_floor),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_floor_level         (rsp_floor_level),
      .rsp_calibrating         (rsp_calibrating),
      .rsp_channel_busy        (rsp_channel_busy),
      .rsp_floor_updated       (rsp_floor_updated),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .error_count             (error_count),
      .outstanding             (outstanding),
      .run_floor               (run_floor),
      .run_count               (run_count)
   );

   // receiver stalls, drawn fresh every cycle
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // watchdog: a long stretch with no request and no response taken means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // keep a sample inside the 9-bit port range
   function automatic int clip_rssi(input int v);
      if (v < -256) return -256;
      if (v > 255) return 255;
      return v;
   endfunction

   // one request; called at a falling edge, returns at the falling edge after
   // it was taken, leaving valid high so back-to-back requests need no toggle
   task automatic drive_request(input int rssi, input bit listen, input bit in_pkt,
                                input bit restart, input bit clear);
      int level;
      level = clip_rssi(rssi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid               <= 1'b1;
      req_rssi                <= level[RSSI_W-1:0];
      req_listening           <= listen;
      req_packet_in_progress  <= in_pkt;
      req_restart_calibration <= restart;
      req_clear_floor         <= clear;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // any request at all, full 9-bit sample range
   task automatic drive_random(input int clear_pct);
      drive_request(int'($urandom_range(0, 511)) - 256, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(99) < clear_pct);
   endtask

   // stop sending until every response is back, then a few quiet cycles
   task automatic settle(input int extra_cycles);
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (extra_cycles) @(negedge clock);
   endtask

   // threshold writes only happen with the pipeline empty
   task automatic write_threshold(input int value);
      settle(3);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[THRESH_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // one calibration run: open it, fill it to the full count, then close it
   task automatic collect_run(input run_kind_type kind);
      int tries;
      int v;
      // zero-sum runs start from a cleared floor so both signs are accepted
      if (kind == RUN_ZERO)
         drive_request(int'($urandom_range(0, 511)) - 256, 1'b0, 1'b0,
                       1'($urandom_range(0, 1)), 1'b1);
      else if (run_count >= NUM_SAMPLES_DEF)
         drive_request(run_floor, 1'($urandom_range(0, 1)), 1'b0, 1'b1, 1'b0);
      tries = 0;
      while (run_count < NUM_SAMPLES_DEF && tries < 150) begin
         tries++;
         case (kind)
            RUN_CLIMB: begin
               // right under the acceptance margin, pulls the floor up
               drive_request(run_floor + int'($urandom_range(11, 13)), 1'b1, 1'b0, 1'b0, 1'b0);
            end
            RUN_PLUNGE: begin
               // far below, the average lands under the lower clamp
               drive_request(-256 + int'($urandom_range(0, 120)), 1'b1, 1'b0, 1'b0, 1'b0);
            end
            RUN_ZERO: begin
               v = $urandom_range(0, 13);
               drive_request(v, 1'b1, 1'b0, 1'b0, 1'b0);
               drive_request(-v, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            default: begin
               // mostly samples around the floor, all under the margin,
               // with the odd unrelated request mixed in
               if ($urandom_range(9) == 0)
                  drive_random(5);
               else
                  drive_request(run_floor - 40 + int'($urandom_range(0, 53)),
                                1'b1, 1'b0, 1'b0, 1'b0);
            end
         endcase
      end
      // close: climbs always take their average, others vary how it ends
      if (kind == RUN_CLIMB) begin
         drive_request(run_floor, 1'b1, 1'b0, 1'b0, 1'b0);
      end else begin
         case ($urandom_range(0, 3))
            // listening with the run full computes the average
            0: drive_request(run_floor, 1'b1, 1'b0, 1'b0, 1'b0);
            // not listening with the run full also computes the average
            1: drive_request(int'($urandom_range(0, 511)) - 256, 1'b0,
                             1'($urandom_range(0, 1)), 1'b0, 1'b0);
            // restart throws away the pending average
            2: drive_request(run_floor, 1'($urandom_range(0, 1)), 1'b0, 1'b1, 1'b0);
            // packet in progress also lets the average through
            default: drive_request(run_floor + 20, 1'b1, 1'b1, 1'b0, 1'b0);
         endcase
      end
   endtask

   initial begin
      int phase_idx;
      int pick;
      int climbs;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: threshold at its top, boundaries of every field and flag
      write_threshold(127);
      drive_request(-256, 1'b1, 1'b0, 1'b0, 1'b0);   // lowest sample, accepted
      drive_request(255, 1'b1, 1'b0, 1'b0, 1'b0);    // highest sample, rejected, busy
      drive_request(13, 1'b1, 1'b0, 1'b0, 1'b0);     // just under the margin
      drive_request(14, 1'b1, 1'b0, 1'b0, 1'b0);     // on the margin, rejected
      drive_request(-160, 1'b1, 1'b1, 1'b0, 1'b0);   // packet in progress, ignored
      drive_request(20, 1'b0, 1'b0, 1'b0, 1'b0);     // not listening
      drive_request(0, 1'b1, 1'b0, 1'b1, 1'b0);      // restart during a run, ignored
      drive_request(127, 1'b0, 1'b0, 1'b0, 1'b0);    // equal to floor plus threshold
      drive_request(128, 1'b0, 1'b0, 1'b0, 1'b0);    // one above, busy
      drive_request(0, 1'b0, 1'b0, 1'b1, 1'b1);      // clear together with restart
      drive_request(-1, 1'b1, 1'b1, 1'b1, 1'b1);     // every flag at once
      drive_request(-2, 1'b1, 1'b0, 1'b0, 1'b1);     // clear then collect
      write_threshold(0);
      drive_request(255, 1'b0, 1'b0, 1'b0, 1'b0);    // busy check off
      drive_request(0, 1'b0, 1'b0, 1'b0, 1'b1);

      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               write_threshold(1);
            end
            1: begin
               send_idle_pct = 86;
               stall_pct     = 0;
               write_threshold($urandom_range(2, 126));
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 86;
               write_threshold(127);
            end
            default: begin
               send_idle_pct = 17;
               stall_pct     = 17;
               write_threshold(0);
            end
         endcase
         if (phase_idx == 0) begin
            // climb the floor to the top and one run past it, so the
            // average saturates at the upper limit
            climbs = 0;
            while (run_floor < FLOOR_MAX && climbs < 20) begin
               collect_run(RUN_CLIMB);
               climbs++;
            end
            collect_run(RUN_CLIMB);
            collect_run(RUN_PLUNGE);
            collect_run(RUN_ZERO);
            drive_request(0, 1'b0, 1'b0, 1'b0, 1'b0);  // zero sum, floor held
         end
         if (phase_idx == 2) begin
            // hold off mid-phase until the pipeline has drained
            collect_run(RUN_NORMAL);
            settle(0);
         end
         while (sent < FIRST_PHASE_ITEMS + phase_idx * PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
               collect_run(RUN_NORMAL);
            else if (pick < 6)
               collect_run(RUN_CLIMB);
            else if (pick == 6)
               collect_run(RUN_PLUNGE);
            else if (pick == 7)
               collect_run(RUN_ZERO);
            else
               repeat ($urandom_range(3, 15)) drive_random(12);
         end
      end

      // drain, let any stray response show up, then the verdict
      settle(4);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
